/* rtl/priority_ready_scheduler_defines.svh */
// Assertion macros for the priority ready scheduler.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef PRIORITY_READY_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

/* rtl/prs_pkg.sv */
// Shared constants, codes and control structs for the priority ready scheduler.
// No dependencies; imported by prs_queue and priority_ready_scheduler.
package prs_pkg;

	localparam int NUM_PROCS  = 16;
	localparam int PRIO_BITS  = 8;
	localparam int DEFER_BITS = 8;
	localparam int PID_W      = 4;
	localparam int IDX_W      = $clog2(NUM_PROCS);
	localparam int CNT_W      = $clog2(NUM_PROCS + 1);

	localparam logic [1:0] CMD_MAKE_READY  = 2'd0;
	localparam logic [1:0] CMD_RESCHED     = 2'd1;
	localparam logic [1:0] CMD_DEFER_START = 2'd2;
	localparam logic [1:0] CMD_DEFER_STOP  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ID    = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_NONE      = 3'd4;

	typedef enum logic [1:0] {
		Q_NOP,
		Q_ADD,
		Q_POP
	} queue_op_t;

	typedef struct packed {
		queue_op_t              op;
		logic [IDX_W-1:0]       rd_idx;
		logic [IDX_W-1:0]       wr_idx;
		logic [PID_W-1:0]       ins_id;
		logic [PRIO_BITS-1:0]   ins_key;
	} queue_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0]       count;
		logic [PID_W-1:0]       head_id;
		logic [PRIO_BITS-1:0]   head_key;
		logic                   key_ge;
		logic                   id_hit;
	} queue_stat_t;

endpackage

/* rtl/prs_queue.sv */
// Ready list storage with the shared scan comparator.
// Depends on prs_pkg; driven one operation per cycle by the scheduler sequencer.
module prs_queue import prs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_ctrl_t ctrl,
	output queue_stat_t stat
);

	logic [PID_W-1:0]     ids_q  [NUM_PROCS];
	logic [PRIO_BITS-1:0] keys_q [NUM_PROCS];
	logic [CNT_W-1:0]     count_q;

	// shared compare unit: one entry per cycle against the item being placed
	assign stat.count    = count_q;
	assign stat.head_id  = ids_q[0];
	assign stat.head_key = keys_q[0];
	assign stat.key_ge   = keys_q[ctrl.rd_idx] >= ctrl.ins_key;
	assign stat.id_hit   = ids_q[ctrl.rd_idx] == ctrl.ins_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (ctrl.op)
				Q_ADD:   count_q <= count_q + CNT_W'(1);
				Q_POP:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			Q_ADD: begin
				for (int i = 1; i < NUM_PROCS; i++) begin
					if (IDX_W'(i) > ctrl.wr_idx) begin
						ids_q[i]  <= ids_q[i-1];
						keys_q[i] <= keys_q[i-1];
					end
				end
				ids_q[ctrl.wr_idx]  <= ctrl.ins_id;
				keys_q[ctrl.wr_idx] <= ctrl.ins_key;
			end
			Q_POP: begin
				for (int i = 0; i < NUM_PROCS - 1; i++) begin
					ids_q[i]  <= ids_q[i+1];
					keys_q[i] <= keys_q[i+1];
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/priority_ready_scheduler.sv */
// Priority ready scheduler top level: command decode, sequencer, result register.
// Depends on prs_pkg, prs_queue and priority_ready_scheduler_defines.svh.
//
// Usage: present cmd, process_id, priority_req and stays_eligible with start
// high; the command beat is taken at the edge where start is high and busy low.
// Each command yields exactly one result beat: done is high for one cycle with
// status, switched, from_pid, to_pid, slice_reload and deferred. The receiver
// cannot stall, so the result must be captured in that cycle.
// Defer start, and defer stop without a pending reschedule, raise done in the
// cycle after acceptance. A reschedule walks the ready list one entry per cycle
// through the single shared compare unit; a make-ready first scans the list
// and places its entry. Throughput is one command per latency: busy stays
// high until the result beat is issued and drops in the cycle done is high,
// so the next command may be taken then. time_slice is written through
// cfg_we / cfg_wdata; the user must write it only while idle, which the block
// itself does not enforce; reset value 2. Reset (arst_n low) empties the list,
// runs the null process (id 0, key 0), clears the deferral depth and pending
// flag and restores time_slice.
`include "priority_ready_scheduler_defines.svh"

module priority_ready_scheduler import prs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [PID_W-1:0]     process_id,
	input  logic [PRIO_BITS-1:0] priority_req,
	input  logic                 stays_eligible,
	// configuration
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	// result channel
	output logic                 done,
	output logic [2:0]           status,
	output logic                 switched,
	output logic [PID_W-1:0]     from_pid,
	output logic [PID_W-1:0]     to_pid,
	output logic [15:0]          slice_reload,
	output logic                 deferred
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_RESCHED,
		S_POP
	} state_t;

	localparam logic [DEFER_BITS-1:0] DEFER_MAX = '1;
	localparam logic [CNT_W-1:0]      LIST_FULL = CNT_W'(NUM_PROCS);

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 found_q;
	logic                 hit_q;
	logic                 mk_q;       // placing a new process, not the running one
	logic [PID_W-1:0]     ins_id_q;
	logic [PRIO_BITS-1:0] ins_key_q;

	logic [PID_W-1:0]     run_id_q;
	logic [PRIO_BITS-1:0] run_key_q;
	logic                 leaving_q;
	logic [DEFER_BITS-1:0] depth_q;
	logic                 pending_q;
	logic [15:0]          time_slice_q;

	logic                 done_q;
	logic [2:0]           status_q;
	logic                 switched_q;
	logic [PID_W-1:0]     from_q;
	logic [PID_W-1:0]     to_q;
	logic [15:0]          slice_q;
	logic                 deferred_q;

	queue_ctrl_t          qctrl;
	queue_stat_t          qstat;
	logic                 scan_last;
	logic                 place_ok;
	logic                 accept;

	prs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (qctrl),
		.stat   (qstat)
	);

	assign accept    = start && (state_q == S_IDLE);
	assign scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == qstat.count;
	// a placement goes ahead unless the id is already listed or the list is full
	assign place_ok  = !(mk_q && hit_q) && (qstat.count != LIST_FULL);

	// drive the list: read at the scan index, insert at the found slot, pop the head
	always_comb begin
		qctrl.op      = Q_NOP;
		qctrl.rd_idx  = idx_q;
		qctrl.wr_idx  = pos_q[IDX_W-1:0];
		qctrl.ins_id  = ins_id_q;
		qctrl.ins_key = ins_key_q;
		if (state_q == S_PLACE && place_ok) begin
			qctrl.op = Q_ADD;
		end else if (state_q == S_POP) begin
			qctrl.op = Q_POP;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= 16'd2;
		end else if (cfg_we) begin
			time_slice_q <= cfg_wdata;
		end
	end

	// sequencer: holds scheduler state and the result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			pos_q      <= '0;
			found_q    <= 1'b0;
			hit_q      <= 1'b0;
			mk_q       <= 1'b0;
			ins_id_q   <= '0;
			ins_key_q  <= '0;
			run_id_q   <= '0;
			run_key_q  <= '0;
			leaving_q  <= 1'b0;
			depth_q    <= '0;
			pending_q  <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			switched_q <= 1'b0;
			from_q     <= '0;
			to_q       <= '0;
			slice_q    <= '0;
			deferred_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// open a fresh result; fields are only meaningful with done
						status_q   <= ST_OK;
						switched_q <= 1'b0;
						deferred_q <= 1'b0;
						slice_q    <= '0;
						from_q     <= run_id_q;
						to_q       <= run_id_q;
						unique case (cmd)
							CMD_MAKE_READY: begin
								if ({1'b0, process_id} >= (PID_W+1)'(NUM_PROCS) ||
								    process_id == run_id_q) begin
									status_q <= ST_BAD_ID;
									done_q   <= 1'b1;
								end else begin
									ins_id_q  <= process_id;
									ins_key_q <= priority_req;
									mk_q      <= 1'b1;
									idx_q     <= '0;
									pos_q     <= qstat.count;
									found_q   <= 1'b0;
									hit_q     <= 1'b0;
									state_q   <= (qstat.count == '0) ? S_PLACE : S_SCAN;
								end
							end
							CMD_RESCHED: begin
								leaving_q <= !stays_eligible;
								state_q   <= S_RESCHED;
							end
							CMD_DEFER_START: begin
								if (depth_q == DEFER_MAX) begin
									status_q <= ST_OVERFLOW;
								end else begin
									if (depth_q == '0) begin
										pending_q <= 1'b0;
									end
									depth_q <= depth_q + DEFER_BITS'(1);
								end
								done_q <= 1'b1;
							end
							CMD_DEFER_STOP: begin
								if (depth_q == '0) begin
									status_q <= ST_UNDERFLOW;
									done_q   <= 1'b1;
								end else begin
									depth_q <= depth_q - DEFER_BITS'(1);
									if (depth_q == DEFER_BITS'(1) && pending_q) begin
										// last level released: run the held reschedule
										pending_q <= 1'b0;
										state_q   <= S_RESCHED;
									end else begin
										done_q <= 1'b1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					// one listed entry per cycle through the shared comparator
					if (qstat.id_hit) begin
						hit_q <= 1'b1;
					end
					if (!found_q && !qstat.key_ge) begin
						pos_q   <= CNT_W'(idx_q);
						found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= S_PLACE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_PLACE: begin
					if (place_ok) begin
						state_q <= mk_q ? S_RESCHED : S_POP;
					end else begin
						// duplicate id or full list; a failed re-queue drops the switch quietly
						if (mk_q) begin
							status_q <= ST_BAD_ID;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RESCHED: begin
					if (depth_q != '0) begin
						pending_q  <= 1'b1;
						deferred_q <= 1'b1;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (!leaving_q) begin
						if (qstat.count == '0 || run_key_q > qstat.head_key) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							// re-queue the running process behind equal keys
							ins_id_q  <= run_id_q;
							ins_key_q <= run_key_q;
							mk_q      <= 1'b0;
							idx_q     <= '0;
							pos_q     <= qstat.count;
							found_q   <= 1'b0;
							hit_q     <= 1'b0;
							state_q   <= S_SCAN;
						end
					end else if (qstat.count == '0) begin
						status_q <= ST_NONE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					// advance the head into the running slot
					run_id_q   <= qstat.head_id;
					run_key_q  <= qstat.head_key;
					leaving_q  <= 1'b0;
					switched_q <= 1'b1;
					slice_q    <= time_slice_q;
					to_q       <= qstat.head_id;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign switched     = switched_q;
	assign from_pid     = from_q;
	assign to_pid       = to_q;
	assign slice_reload = slice_q;
	assign deferred     = deferred_q;

	// a switch always brings in a different process
	`PRS_ASSERT_IMPL(a_switch_changes_pid, done && switched, from_pid != to_pid)
	// without a switch the running process is unchanged
	`PRS_ASSERT_IMPL(a_stay_keeps_pid, done && !switched, to_pid == from_pid)
	// a held reschedule moves nothing and reports no error
	`PRS_ASSERT_IMPL(a_defer_quiet, done && deferred, !switched && status == ST_OK)
	// every accepted beat either starts work or reports at once
	`PRS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

endmodule

/* dv/priority_ready_scheduler_check.sv */
// Scoreboard for the priority ready scheduler: watches the command, config and result ports.
// It predicts each result beat from its own copy of the scheduler state and compares fields.
// Depends on prs_pkg for widths and codes.
module priority_ready_scheduler_check import prs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [PID_W-1:0]     process_id,
	input  logic [PRIO_BITS-1:0] priority_req,
	input  logic                 stays_eligible,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 done,
	input  logic [2:0]           status,
	input  logic                 switched,
	input  logic [PID_W-1:0]     from_pid,
	input  logic [PID_W-1:0]     to_pid,
	input  logic [15:0]          slice_reload,
	input  logic                 deferred,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int DEFER_TOP = (1 << DEFER_BITS) - 1;

	typedef struct packed {
		logic [2:0]       status;
		logic             switched;
		logic [PID_W-1:0] from_pid;
		logic [PID_W-1:0] to_pid;
		logic [15:0]      slice_reload;
		logic             deferred;
	} sched_beat_t;

	// ready list, highest key first, arrival order among equal keys
	logic [PID_W-1:0]     ready_pid [NUM_PROCS];
	logic [PRIO_BITS-1:0] ready_key [NUM_PROCS];
	int                   ready_len;
	logic [PID_W-1:0]     run_pid;
	logic [PRIO_BITS-1:0] run_key;
	logic                 run_leaving;
	int                   defer_lvl;
	logic                 resched_owed;
	logic [15:0]          slice_val;
	sched_beat_t          expected_beats [$];

	function automatic logic ready_holds(logic [PID_W-1:0] pid);
		for (int i = 0; i < ready_len; i++) begin
			if (ready_pid[i] == pid)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic ready_insert(logic [PID_W-1:0] pid, logic [PRIO_BITS-1:0] key);
		int pos;
		pos = 0;
		if (ready_len >= NUM_PROCS)
			return 1'b0;
		while (pos < ready_len && ready_key[pos] >= key)
			pos++;
		for (int i = ready_len; i > pos; i--) begin
			ready_pid[i] = ready_pid[i-1];
			ready_key[i] = ready_key[i-1];
		end
		ready_pid[pos] = pid;
		ready_key[pos] = key;
		ready_len++;
		return 1'b1;
	endfunction

	function automatic void reschedule(inout sched_beat_t r);
		if (defer_lvl > 0) begin
			resched_owed = 1'b1;
			r.deferred = 1'b1;
			return;
		end
		if (!run_leaving) begin
			// keep the running process only while it strictly beats the head
			if (ready_len == 0 || run_key > ready_key[0])
				return;
			if (!ready_insert(run_pid, run_key))
				return;
		end else if (ready_len == 0) begin
			r.status = ST_NONE;
			return;
		end
		run_pid = ready_pid[0];
		run_key = ready_key[0];
		for (int i = 1; i < ready_len; i++) begin
			ready_pid[i-1] = ready_pid[i];
			ready_key[i-1] = ready_key[i];
		end
		ready_len--;
		run_leaving = 1'b0;
		r.switched = 1'b1;
	endfunction

	function automatic sched_beat_t predict_beat(logic [1:0] code, logic [PID_W-1:0] pid,
			logic [PRIO_BITS-1:0] prio, logic stays);
		sched_beat_t r;
		r = '0;
		r.from_pid = run_pid;
		case (code)
			CMD_MAKE_READY: begin
				if (int'(pid) >= NUM_PROCS || pid == run_pid || ready_holds(pid) ||
						!ready_insert(pid, prio))
					r.status = ST_BAD_ID;
				else
					reschedule(r);
			end
			CMD_RESCHED: begin
				run_leaving = !stays;
				reschedule(r);
			end
			CMD_DEFER_START: begin
				if (defer_lvl >= DEFER_TOP) begin
					r.status = ST_OVERFLOW;
				end else begin
					if (defer_lvl == 0)
						resched_owed = 1'b0;
					defer_lvl++;
				end
			end
			default: begin
				if (defer_lvl == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					defer_lvl--;
					if (defer_lvl == 0 && resched_owed) begin
						resched_owed = 1'b0;
						reschedule(r);
					end
				end
			end
		endcase
		r.to_pid = run_pid;
		r.slice_reload = r.switched ? slice_val : 16'd0;
		return r;
	endfunction

	task automatic report(string msg);
		$display("%0t scheduler check: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [15:0] seen, logic [15:0] want);
		if (seen !== want)
			report($sformatf("%s got %0h, want %0h", name, seen, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_beat_t seen;
		sched_beat_t want;
		if (!arst_n) begin
			ready_len = 0;
			run_pid = '0;
			run_key = '0;
			run_leaving = 1'b0;
			defer_lvl = 0;
			resched_owed = 1'b0;
			slice_val = 16'd2;
			mismatches = 0;
			expected_beats.delete();
		end else begin
			// the result beat at this edge belongs to an earlier command
			if (done) begin
				seen = {status, switched, from_pid, to_pid, slice_reload, deferred};
				if (expected_beats.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					want = expected_beats.pop_front();
					check_field("status", 16'(seen.status), 16'(want.status));
					check_field("switched", 16'(seen.switched), 16'(want.switched));
					check_field("from_pid", 16'(seen.from_pid), 16'(want.from_pid));
					check_field("to_pid", 16'(seen.to_pid), 16'(want.to_pid));
					check_field("slice_reload", seen.slice_reload, want.slice_reload);
					check_field("deferred", 16'(seen.deferred), 16'(want.deferred));
				end
			end
			if (cfg_we)
				slice_val = cfg_wdata;
			if (start && !busy)
				expected_beats.push_back(predict_beat(cmd, process_id, priority_req,
					stays_eligible));
		end
		outstanding <= expected_beats.size();
	end

endmodule

/* dv/priority_ready_scheduler_test.sv */
// Testbench top for the priority ready scheduler: clock, reset, command stimulus and verdict.
// Depends on prs_pkg, the scheduler RTL and priority_ready_scheduler_check.
module priority_ready_scheduler_test;
	import prs_pkg::*;

	// idle cycles with no beat on either channel before the run is abandoned;
	// it lies well above the longest command and the longest sender gap
	localparam int STALL_LIMIT = 1000;
	// settle time after the last result beat
	localparam int TAIL_CYCLES = 48;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           cmd = CMD_MAKE_READY;
	logic [PID_W-1:0]     process_id = '0;
	logic [PRIO_BITS-1:0] priority_req = '0;
	logic                 stays_eligible = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [15:0]          cfg_wdata = '0;
	logic                 done;
	logic [2:0]           status;
	logic                 switched;
	logic [PID_W-1:0]     from_pid;
	logic [PID_W-1:0]     to_pid;
	logic [15:0]          slice_reload;
	logic                 deferred;
	int                   mismatches;
	int                   outstanding;
	int                   stall_cycles = 0;
	int                   burst_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	priority_ready_scheduler DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.process_id     (process_id),
		.priority_req   (priority_req),
		.stays_eligible (stays_eligible),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.status         (status),
		.switched       (switched),
		.from_pid       (from_pid),
		.to_pid         (to_pid),
		.slice_reload   (slice_reload),
		.deferred       (deferred)
	);

	priority_ready_scheduler_check sched_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.process_id     (process_id),
		.priority_req   (priority_req),
		.stays_eligible (stays_eligible),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.status         (status),
		.switched       (switched),
		.from_pid       (from_pid),
		.to_pid         (to_pid),
		.slice_reload   (slice_reload),
		.deferred       (deferred),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	// Watchdog: count cycles in which neither a command beat nor a result beat
	// is taken, and abandon the run once the count reaches the limit.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("priority_ready_scheduler_test: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Present one command beat and hold it until the edge that takes it.
	// Bursts of random length follow each other; between bursts drop start
	// for a random gap, so the next beat lands on every phase of the block's
	// work. About one burst in four runs straight on with no gap at all.
	task automatic send_command(logic [1:0] code, logic [PID_W-1:0] pid,
			logic [PRIO_BITS-1:0] prio, logic stays);
		int gap;
		start <= 1'b1;
		cmd <= code;
		process_id <= pid;
		priority_req <= prio;
		stays_eligible <= stays;
		do @(posedge clk); while (busy);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop start and wait until every expected result beat has come back.
	// Every command yields a result, so an empty scoreboard means idle.
	task automatic wait_quiet();
		if (start)
			start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Write time_slice while the block is idle; hold the enable for one edge.
	task automatic write_slice(logic [15:0] value);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random command. Make-ready dominates so the list fills up; keys
	// come half from a few clustered values so equal-key ordering and
	// round-robin among ties get plenty of traffic. Defer stops slightly
	// outnumber starts to keep the nesting shallow and hit underflow often.
	// Fields a command ignores still carry random values.
	task automatic random_command();
		int pick;
		logic [PRIO_BITS-1:0] prio;
		logic [PID_W-1:0] pid;
		logic stays;
		pick = $urandom_range(0, 99);
		pid = PID_W'($urandom_range(0, NUM_PROCS - 1));
		stays = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1))
			prio = PRIO_BITS'($urandom_range(0, 255));
		else
			prio = PRIO_BITS'($urandom_range(0, 3) * 64);
		if (pick < 45) begin
			send_command(CMD_MAKE_READY, pid, prio, stays);
		end else if (pick < 75) begin
			// leaving a little more often than staying keeps the list draining
			send_command(CMD_RESCHED, pid, prio, $urandom_range(0, 99) < 45);
		end else if (pick < 87) begin
			send_command(CMD_DEFER_START, pid, prio, stays);
		end else begin
			send_command(CMD_DEFER_STOP, pid, prio, stays);
		end
	endtask

	initial begin
		// hold reset low, then release it on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, slice at its lower extreme
		write_slice(16'd1);
		// defer stop at depth zero: underflow
		send_command(CMD_DEFER_STOP, 4'hf, 8'hff, 1'b1);
		// null process leaves with an empty list: nothing ready
		send_command(CMD_RESCHED, 4'hf, 8'hff, 1'b0);
		// make-ready of the running id: bad id
		send_command(CMD_MAKE_READY, 4'h0, 8'h00, 1'b0);
		// first real process takes over from the leaving null process
		send_command(CMD_MAKE_READY, 4'h5, 8'd10, 1'b0);
		send_command(CMD_MAKE_READY, 4'h5, 8'd10, 1'b0);
		// equal key does not keep the runner: it is queued behind the newcomer
		send_command(CMD_MAKE_READY, 4'h3, 8'd10, 1'b0);
		// id already listed: bad id
		send_command(CMD_MAKE_READY, 4'h5, 8'd200, 1'b1);
		// highest key preempts
		send_command(CMD_MAKE_READY, 4'hf, 8'hff, 1'b0);
		send_command(CMD_MAKE_READY, 4'h0, 8'h00, 1'b1);
		send_command(CMD_MAKE_READY, 4'ha, 8'h00, 1'b0);
		// runner strictly beats the head: stays
		send_command(CMD_RESCHED, 4'h0, 8'h00, 1'b1);
		// reschedules under deferral are only recorded
		send_command(CMD_DEFER_START, 4'h0, 8'h00, 1'b0);
		send_command(CMD_MAKE_READY, 4'h9, 8'hff, 1'b0);
		send_command(CMD_DEFER_START, 4'h0, 8'h00, 1'b0);
		send_command(CMD_RESCHED, 4'h0, 8'h00, 1'b0);
		send_command(CMD_DEFER_STOP, 4'h0, 8'h00, 1'b0);
		// depth back to zero: the owed reschedule runs now
		send_command(CMD_DEFER_STOP, 4'h0, 8'h00, 1'b0);
		send_command(CMD_RESCHED, 4'h0, 8'h00, 1'b1);
		send_command(CMD_RESCHED, 4'h0, 8'h00, 1'b0);
		send_command(CMD_MAKE_READY, 4'h7, 8'd10, 1'b1);
		// round robin among equal keys
		send_command(CMD_RESCHED, 4'h0, 8'h00, 1'b1);
		send_command(CMD_RESCHED, 4'h0, 8'h00, 1'b1);
		// deferral with nothing owed: plain ok on both ends
		send_command(CMD_DEFER_START, 4'h0, 8'h00, 1'b1);
		send_command(CMD_DEFER_STOP, 4'h0, 8'h00, 1'b1);

		// deferral depth to saturation and back, slice at its upper extreme
		write_slice(16'hffff);
		repeat ((1 << DEFER_BITS) - 1)
			send_command(CMD_DEFER_START, PID_W'($urandom_range(0, 15)),
				PRIO_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		// one more start at full depth: overflow
		send_command(CMD_DEFER_START, 4'h0, 8'h00, 1'b0);
		send_command(CMD_RESCHED, 4'h0, 8'h00, 1'b0);
		send_command(CMD_MAKE_READY, PID_W'($urandom_range(0, 15)),
			PRIO_BITS'($urandom_range(0, 255)), 1'b0);
		repeat ((1 << DEFER_BITS) - 1)
			send_command(CMD_DEFER_STOP, PID_W'($urandom_range(0, 15)),
				PRIO_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_command(CMD_DEFER_STOP, 4'h0, 8'h00, 1'b0);

		// random part in four phases, each under its own slice value
		write_slice(16'd2);
		repeat (153) random_command();
		write_slice(16'($urandom_range(1, 65535)));
		repeat (153) random_command();
		write_slice(16'd1);
		repeat (153) random_command();
		write_slice(16'($urandom_range(1, 65535)));
		repeat (153) random_command();

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("priority_ready_scheduler_test: done, clean");
		else
			$display("priority_ready_scheduler_test: done, errors");
		$finish;
	end

endmodule
